// File: rtl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types, codes and defaults of the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  // default table size
  localparam int SLOTS_DEF = 64;

  // field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  // input beat
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

  // one slot of the table memory
  typedef struct packed {
    logic              vacant;
    logic              tomb;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic              clr_wr;
    logic              load;
    logic              start;
    logic              rd;
    logic              advance;
    logic              wr_insert;
    logic              wr_remove;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_set;
    logic [STAT_W-1:0] res_status;
    logic              res_found;
    logic              push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              clr_last;
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              vacant;
    logic              tomb;
    logic              match;
    logic              last;
    logic              out_busy;
  } sts_t;

endpackage

// File: rtl/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing table of byte keys and 32-bit values with quadratic probing.
// ----------------------------------------------------------------------------
// After reset the block walks the slot memory once to mark every slot vacant,
// with in_ready low. Each beat then passes through a home-slot step, a read
// and a check for each slot probed, and a response step before the next
// acceptance: every probe is a read of the single-port slot memory followed by
// a check of the registered read data. Inserts refused at the load limit,
// lookups and removes on an empty table, and the unused operation code skip
// the probes; the longest chain is SLOTS probes, after which an insert is
// refused. The response step waits while the output register holds a stalled
// result. A new beat is taken while the previous result still waits there.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
  parameter int SLOTS = qpht_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qpht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qpht_pkg::out_item_t out_data
);

  qpht_pkg::cmd_t cmd;
  qpht_pkg::sts_t sts;

  // sequencer
  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath with slot memory
  qpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl
// Sequencer: clearing pass, item intake, probe read/check loop, result push.
// ----------------------------------------------------------------------------
module qpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qpht_pkg::sts_t sts,
  output qpht_pkg::cmd_t cmd
);

  qpht_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpht_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      qpht_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = qpht_pkg::S_IDLE;
        end
      end
      qpht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = qpht_pkg::S_HOME;
        end
      end
      qpht_pkg::S_HOME: begin
        // set up the probe chain, or answer at once
        cmd.start = 1'b1;
        if (sts.func == qpht_pkg::FN_INSERT) begin
          if (sts.full) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = qpht_pkg::ST_FULL;
            state_nxt      = qpht_pkg::S_RESP;
          end else begin
            state_nxt = qpht_pkg::S_READ;
          end
        end else if ((sts.func == qpht_pkg::FN_REMOVE ||
                      sts.func == qpht_pkg::FN_LOOKUP) && !sts.empty) begin
          state_nxt = qpht_pkg::S_READ;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = qpht_pkg::ST_NOT_FOUND;
          state_nxt      = qpht_pkg::S_RESP;
        end
      end
      qpht_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = qpht_pkg::S_CHECK;
      end
      qpht_pkg::S_CHECK: begin
        state_nxt   = qpht_pkg::S_RESP;
        cmd.res_set = 1'b1;
        if (sts.func == qpht_pkg::FN_INSERT) begin
          if (sts.vacant || sts.tomb) begin
            cmd.wr_insert  = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.res_status = qpht_pkg::ST_INSERTED;
          end else if (sts.match) begin
            cmd.wr_insert  = 1'b1;
            cmd.res_status = qpht_pkg::ST_UPDATED;
          end else if (sts.last) begin
            cmd.res_status = qpht_pkg::ST_FULL;
          end else begin
            cmd.res_set = 1'b0;
            cmd.advance = 1'b1;
            state_nxt   = qpht_pkg::S_READ;
          end
        end else begin
          if (sts.vacant) begin
            cmd.res_status = qpht_pkg::ST_NOT_FOUND;
          end else if (sts.match) begin
            if (sts.func == qpht_pkg::FN_REMOVE) begin
              cmd.wr_remove  = 1'b1;
              cmd.cnt_dec    = 1'b1;
              cmd.res_status = qpht_pkg::ST_REMOVED;
            end else begin
              cmd.res_found  = 1'b1;
              cmd.res_status = qpht_pkg::ST_FOUND;
            end
          end else if (sts.last) begin
            cmd.res_status = qpht_pkg::ST_NOT_FOUND;
          end else begin
            // tombstone or other key: keep probing
            cmd.res_set = 1'b0;
            cmd.advance = 1'b1;
            state_nxt   = qpht_pkg::S_READ;
          end
        end
      end
      qpht_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = qpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = qpht_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/qpht_dp.sv
// ----------------------------------------------------------------------------
// qpht_dp
// Datapath: item latch, probe address generator, slot memory, live count,
// result and output registers.
// ----------------------------------------------------------------------------
module qpht_dp #(
  parameter int SLOTS = qpht_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qpht_pkg::in_item_t  in_data,
  input  qpht_pkg::cmd_t      cmd,
  output qpht_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output qpht_pkg::out_item_t out_data
);

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int CXP = CW + 3;
  localparam int RW  = SW + 7;
  localparam int CXW = (CW > qpht_pkg::CNT_W) ? CW : qpht_pkg::CNT_W;
  localparam int ENT_W = $bits(qpht_pkg::slot_t);

  qpht_pkg::in_item_t          item_r;
  logic [SW-1:0]               home_r, sq_r, odd_r, idx_r, slot_r, clr_r;
  logic [CW-1:0]               count_r;
  logic [qpht_pkg::STAT_W-1:0] res_status_r;
  logic [qpht_pkg::VAL_W-1:0]  res_value_r;
  logic                        out_valid_r;
  qpht_pkg::out_item_t         out_data_r;

  logic [RW-1:0]               rem;
  logic [SW-1:0]               home;
  logic [SW:0]                 psum, sqsum, oddsum;
  logic [SW-1:0]               paddr, sq_nxt, odd_nxt;
  logic                        ram_we;
  logic [SW-1:0]               ram_addr;
  qpht_pkg::slot_t             ram_wdata, ram_rdata;
  logic [CXW-1:0]              cnt_ext;

  // home slot: key mod SLOTS by six compare-subtract steps
  always_comb begin
    rem = RW'(item_r.key);
    for (int k = 5; k >= 0; k--) begin
      if (rem >= (RW'(SLOTS) << k)) begin
        rem = rem - (RW'(SLOTS) << k);
      end
    end
    home = rem[SW-1:0];
  end

  // probe address and incremental square: sq += odd, odd += 2, both mod SLOTS
  always_comb begin
    psum    = {1'b0, home_r} + {1'b0, sq_r};
    paddr   = (psum >= (SW+1)'(SLOTS)) ? SW'(psum - (SW+1)'(SLOTS)) : psum[SW-1:0];
    sqsum   = {1'b0, sq_r} + {1'b0, odd_r};
    sq_nxt  = (sqsum >= (SW+1)'(SLOTS)) ? SW'(sqsum - (SW+1)'(SLOTS)) : sqsum[SW-1:0];
    oddsum  = {1'b0, odd_r} + (SW+1)'(2);
    odd_nxt = (oddsum >= (SW+1)'(SLOTS)) ? SW'(oddsum - (SW+1)'(SLOTS)) : oddsum[SW-1:0];
  end

  // item latch and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.start) begin
      home_r <= home;
      sq_r   <= '0;
      odd_r  <= SW'(1);
      idx_r  <= '0;
    end else if (cmd.advance) begin
      sq_r  <= sq_nxt;
      odd_r <= odd_nxt;
      idx_r <= idx_r + SW'(1);
    end
    if (cmd.rd) begin
      slot_r <= paddr;
    end
  end

  // memory port select
  always_comb begin
    ram_we    = cmd.clr_wr | cmd.wr_insert | cmd.wr_remove;
    ram_addr  = slot_r;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_addr         = clr_r;
      ram_wdata.vacant = 1'b1;
    end else if (cmd.rd) begin
      ram_addr = paddr;
    end
    if (cmd.wr_insert) begin
      ram_wdata.key   = item_r.key;
      ram_wdata.value = item_r.value;
    end else if (cmd.wr_remove) begin
      ram_wdata.tomb = 1'b1;
    end
  end

  qpht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // clearing pointer, live count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + SW'(1);
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = CXW'(count_r);

  // result and output payload
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= cmd.res_found ? ram_rdata.value : '0;
    end
    if (cmd.push) begin
      out_data_r.status      <= res_status_r;
      out_data_r.value_out   <= res_value_r;
      out_data_r.entry_count <= cnt_ext[qpht_pkg::CNT_W-1:0];
    end
  end

  // status to controller
  always_comb begin
    sts.clr_last = (clr_r == SW'(SLOTS - 1));
    sts.func     = item_r.func;
    sts.full     = ((CXP'(count_r) + CXP'(1)) << 2) > CXP'(3 * SLOTS);
    sts.empty    = (count_r == '0);
    sts.vacant   = ram_rdata.vacant;
    sts.tomb     = ram_rdata.tomb;
    sts.match    = !ram_rdata.vacant && !ram_rdata.tomb && (ram_rdata.key == item_r.key);
    sts.last     = (idx_r == SW'(SLOTS - 1));
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module qpht_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input qpht_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input qpht_pkg::out_item_t out_data
);

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one item at a time: intake closes after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("intake stayed open after acceptance");

  // value word only carried by a successful lookup
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != qpht_pkg::ST_FOUND |-> out_data.value_out == '0)
    else $error("nonzero value on a result other than found");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
